// File: rtl/nmt_pkg.sv
// Shared types, codes and helpers for the NAT mapping table.
package nmt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam logic [2:0] REQ_OUTBOUND = 3'd0;
   localparam logic [2:0] REQ_INBOUND  = 3'd1;
   localparam logic [2:0] REQ_ADD_SRC  = 3'd2;
   localparam logic [2:0] REQ_ADD_DST  = 3'd3;
   localparam logic [2:0] REQ_TICK     = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [2:0] CSR_GATEWAY_ADDR  = 3'd0;
   localparam logic [2:0] CSR_PORT_FIRST    = 3'd1;
   localparam logic [2:0] CSR_PORT_LAST     = 3'd2;
   localparam logic [2:0] CSR_TCP_TIMEOUT   = 3'd3;
   localparam logic [2:0] CSR_UDP_TIMEOUT   = 3'd4;
   localparam logic [2:0] CSR_OTHER_TIMEOUT = 3'd5;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic [31:0] public_addr;
      logic [15:0] public_port;
      logic [7:0]  protocol;
      logic        found;
      logic [31:0] hit_addr;
      logic [15:0] hit_port;
      logic        free_found;
      logic [6:0]  evict_cnt;
   } token_type;

   typedef struct packed {
      logic        en;
      logic        is_dest;
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic [31:0] public_addr;
      logic [15:0] public_port;
      logic [7:0]  protocol;
      logic [15:0] timeout;
   } fill_type;

   function automatic logic [15:0] timeout_sel(input logic [7:0] proto,
                                               input logic [15:0] tcp,
                                               input logic [15:0] udp,
                                               input logic [15:0] other);
      logic [15:0] t;
      if (proto == PROTO_TCP) t = tcp;
      else if (proto == PROTO_UDP) t = udp;
      else t = other;
      return t;
   endfunction

endpackage

// File: rtl/nmt_cell.sv
// One table entry with its stage of the lookup token chain.
module nmt_cell
   import nmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int CELL_INDEX  = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [31:0]                    now_time,
   input  token_type                      tok_in,
   input  logic [$clog2(TABLE_DEPTH)-1:0] hit_idx_in,
   input  logic [$clog2(TABLE_DEPTH)-1:0] free_idx_in,
   input  fill_type                       fill,
   input  logic [$clog2(TABLE_DEPTH)-1:0] fill_idx,
   output token_type                      tok_out,
   output logic [$clog2(TABLE_DEPTH)-1:0] hit_idx_out,
   output logic [$clog2(TABLE_DEPTH)-1:0] free_idx_out
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

   logic        valid_ff;
   logic        is_dest_ff;
   logic [31:0] local_addr_ff;
   logic [15:0] local_port_ff;
   logic [31:0] public_addr_ff;
   logic [15:0] public_port_ff;
   logic [7:0]  protocol_ff;
   logic [31:0] last_active_ff;
   logic [15:0] timeout_ff;

   token_type     tok_ff, tok_in_next;
   logic [IW-1:0] hit_idx_ff, hit_idx_in_next;
   logic [IW-1:0] free_idx_ff, free_idx_in_next;

   logic        is_lookup, want_dest, key_match, hit, evict, fill_here;
   logic [31:0] idle_time;

   always_comb begin
      is_lookup = (tok_in.kind == REQ_OUTBOUND) || (tok_in.kind == REQ_INBOUND);
      want_dest = (tok_in.kind == REQ_INBOUND);
      key_match = want_dest ?
         (public_addr_ff == tok_in.public_addr && public_port_ff == tok_in.public_port) :
         (local_addr_ff == tok_in.local_addr && local_port_ff == tok_in.local_port);
      hit = tok_in.valid && is_lookup && !tok_in.found && valid_ff &&
            (is_dest_ff == want_dest) && (protocol_ff == tok_in.protocol) && key_match;
      idle_time = now_time - last_active_ff;
      evict = tok_in.valid && (tok_in.kind == REQ_TICK) && valid_ff &&
              (idle_time > {16'd0, timeout_ff});
      fill_here = fill.en && (fill_idx == MY_IDX);

      tok_in_next = tok_in;
      hit_idx_in_next = hit_idx_in;
      free_idx_in_next = free_idx_in;
      if (hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.hit_addr = want_dest ? local_addr_ff : public_addr_ff;
         tok_in_next.hit_port = want_dest ? local_port_ff : public_port_ff;
         hit_idx_in_next = MY_IDX;
      end
      if (tok_in.valid && !valid_ff && !tok_in.free_found) begin
         tok_in_next.free_found = 1'b1;
         free_idx_in_next = MY_IDX;
      end
      if (evict) begin
         tok_in_next.evict_cnt = tok_in.evict_cnt + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (fill_here) valid_ff <= 1'b1;
         else if (evict) valid_ff <= 1'b0;
         tok_ff <= tok_in_next;
      end
      hit_idx_ff <= hit_idx_in_next;
      free_idx_ff <= free_idx_in_next;
   end

   always_ff @(posedge clock) begin
      if (fill_here) begin
         is_dest_ff     <= fill.is_dest;
         local_addr_ff  <= fill.local_addr;
         local_port_ff  <= fill.local_port;
         public_addr_ff <= fill.public_addr;
         public_port_ff <= fill.public_port;
         protocol_ff    <= fill.protocol;
         timeout_ff     <= fill.timeout;
         last_active_ff <= now_time;
      end else if (hit) begin
         last_active_ff <= now_time;
      end
   end

   assign tok_out = tok_ff;
   assign hit_idx_out = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

// File: rtl/nat_mapping_table_core.sv
// Top level of the NAT mapping table: request control, port allocator and cell chain.
// Each request launches a token that walks the chain of TABLE_DEPTH entry cells one cell
// per cycle, collecting the first match, the lowest free slot and evictions on its way;
// the result is registered from the end of that walk, and requests are handled one at a
// time, so the next request is taken only once the previous one has finished. A new
// request is taken while the previous result still waits on rsp_stall. Configuration
// writes are always ready.
module nat_mapping_table_core
   import nmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_local_addr,
   input  logic [15:0] req_local_port,
   input  logic [31:0] req_public_addr,
   input  logic [15:0] req_public_port,
   input  logic [7:0]  req_protocol,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_addr,
   output logic [15:0] rsp_out_port,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_created,
   output logic [6:0]  rsp_evicted_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = $clog2(TABLE_DEPTH);

   logic [31:0] gateway_addr_ff;
   logic [15:0] port_first_ff, port_last_ff;
   logic [15:0] tcp_timeout_ff, udp_timeout_ff, other_timeout_ff;
   logic [15:0] next_port_ff, next_port_in;
   logic [31:0] now_time_ff;

   fsm_type state_ff, state_in;
   token_type head_tok_ff;
   token_type done_tok_ff;
   logic [IW-1:0] done_hit_ff, done_free_ff;

   token_type     tok [TABLE_DEPTH+1];
   logic [IW-1:0] hidx [TABLE_DEPTH+1];
   logic [IW-1:0] fidx [TABLE_DEPTH+1];

   fill_type      fill;
   logic [IW-1:0] fill_idx;
   logic          alloc;
   logic          req_accept, finish_go;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [15:0] rsp_port_ff, rsp_port_in;
   logic [5:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_created_ff, rsp_created_in;
   logic [6:0]  rsp_evict_ff, rsp_evict_in;
   logic [31:0] hit_wide, free_wide;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != FSM_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         gateway_addr_ff  <= 32'd0;
         port_first_ff    <= 16'd1024;
         port_last_ff     <= 16'd65535;
         tcp_timeout_ff   <= 16'd3600;
         udp_timeout_ff   <= 16'd30;
         other_timeout_ff <= 16'd60;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GATEWAY_ADDR:  gateway_addr_ff  <= csr_wdata;
            CSR_PORT_FIRST:    port_first_ff    <= csr_wdata[15:0];
            CSR_PORT_LAST:     port_last_ff     <= csr_wdata[15:0];
            CSR_TCP_TIMEOUT:   tcp_timeout_ff   <= csr_wdata[15:0];
            CSR_UDP_TIMEOUT:   udp_timeout_ff   <= csr_wdata[15:0];
            CSR_OTHER_TIMEOUT: other_timeout_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign tok[0] = head_tok_ff;
   assign hidx[0] = '0;
   assign fidx[0] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      nmt_cell #(
         .TABLE_DEPTH(TABLE_DEPTH),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .now_time    (now_time_ff),
         .tok_in      (tok[g]),
         .hit_idx_in  (hidx[g]),
         .free_idx_in (fidx[g]),
         .fill        (fill),
         .fill_idx    (fill_idx),
         .tok_out     (tok[g+1]),
         .hit_idx_out (hidx[g+1]),
         .free_idx_out(fidx[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         head_tok_ff.valid <= 1'b0;
         now_time_ff <= 32'd0;
         next_port_ff <= 16'd1024;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_tok_ff.valid <= req_accept;
         if (req_accept && req_type == REQ_TICK) now_time_ff <= now_time_ff + 32'd1;
         next_port_ff <= next_port_in;
         if (finish_go) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         head_tok_ff.kind        <= req_type;
         head_tok_ff.local_addr  <= req_local_addr;
         head_tok_ff.local_port  <= req_local_port;
         head_tok_ff.public_addr <= req_public_addr;
         head_tok_ff.public_port <= req_public_port;
         head_tok_ff.protocol    <= req_protocol;
         head_tok_ff.found       <= 1'b0;
         head_tok_ff.hit_addr    <= 32'd0;
         head_tok_ff.hit_port    <= 16'd0;
         head_tok_ff.free_found  <= 1'b0;
         head_tok_ff.evict_cnt   <= 7'd0;
      end
      if (tok[TABLE_DEPTH].valid) begin
         done_tok_ff  <= tok[TABLE_DEPTH];
         done_hit_ff  <= hidx[TABLE_DEPTH];
         done_free_ff <= fidx[TABLE_DEPTH];
      end
      if (finish_go) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_addr_ff    <= rsp_addr_in;
         rsp_port_ff    <= rsp_port_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_created_ff <= rsp_created_in;
         rsp_evict_ff   <= rsp_evict_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      finish_go = 1'b0;
      alloc = 1'b0;
      fill = '0;
      fill_idx = done_free_ff;
      hit_wide = 32'(done_hit_ff);
      free_wide = 32'(done_free_ff);
      rsp_status_in = STATUS_OK;
      rsp_addr_in = 32'd0;
      rsp_port_in = 16'd0;
      rsp_slot_in = 6'd0;
      rsp_created_in = 1'b0;
      rsp_evict_in = 7'd0;

      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (tok[TABLE_DEPTH].valid) state_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            finish_go = !rsp_valid_ff || !rsp_stall;
            if (finish_go) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase

      fill.local_addr  = done_tok_ff.local_addr;
      fill.local_port  = done_tok_ff.local_port;
      fill.protocol    = done_tok_ff.protocol;
      fill.timeout     = timeout_sel(done_tok_ff.protocol, tcp_timeout_ff,
                                     udp_timeout_ff, other_timeout_ff);
      fill.public_port = next_port_ff;
      fill.public_addr = gateway_addr_ff;

      case (done_tok_ff.kind)
         REQ_OUTBOUND, REQ_INBOUND: begin
            if (done_tok_ff.found) begin
               rsp_addr_in = done_tok_ff.hit_addr;
               rsp_port_in = done_tok_ff.hit_port;
               rsp_slot_in = hit_wide[5:0];
            end else if (done_tok_ff.kind == REQ_INBOUND) begin
               rsp_status_in = STATUS_MISS;
            end else if (!done_tok_ff.free_found) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               fill.en = finish_go;
               alloc = finish_go;
               rsp_addr_in = gateway_addr_ff;
               rsp_port_in = next_port_ff;
               rsp_slot_in = free_wide[5:0];
               rsp_created_in = 1'b1;
            end
         end
         REQ_ADD_SRC, REQ_ADD_DST: begin
            if (!done_tok_ff.free_found) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               fill.en = finish_go;
               if (done_tok_ff.kind == REQ_ADD_DST) begin
                  fill.is_dest = 1'b1;
                  fill.public_addr = done_tok_ff.public_addr;
                  fill.public_port = done_tok_ff.public_port;
               end else begin
                  alloc = finish_go;
                  if (done_tok_ff.public_addr != 32'd0)
                     fill.public_addr = done_tok_ff.public_addr;
               end
               rsp_addr_in = fill.public_addr;
               rsp_port_in = fill.public_port;
               rsp_slot_in = free_wide[5:0];
               rsp_created_in = 1'b1;
            end
         end
         REQ_TICK: begin
            rsp_evict_in = done_tok_ff.evict_cnt;
         end
         default: rsp_status_in = STATUS_MISS;
      endcase

      next_port_in = next_port_ff;
      if (alloc) begin
         next_port_in = next_port_ff + 16'd1;
         if (next_port_in > port_last_ff || next_port_in < port_first_ff)
            next_port_in = port_first_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_addr = rsp_addr_ff;
   assign rsp_out_port = rsp_port_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_created = rsp_created_ff;
   assign rsp_evicted_count = rsp_evict_ff;

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[TABLE_DEPTH].valid |-> state_ff == FSM_SCAN)
      else $error("token left the chain outside a scan");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_FINISH))
      else $error("result raised without finishing a transaction");

   a_created_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_created_ff |-> rsp_status_ff == STATUS_OK)
      else $error("created mapping reported with error status");

   a_fill_only_finish: assert property (@(posedge clock) disable iff (reset)
      fill.en |-> state_ff == FSM_FINISH && state_in == FSM_IDLE)
      else $error("table fill outside a finishing transaction");

endmodule
